// File: hw/rtl/rbd_pkg.sv
// rbd_pkg: shared types, constants and helper function of the RGB box downsampler.
// No dependencies; imported by rgb_box_downsampler_unit.
package rbd_pkg;

   // pixel and field widths
   localparam int COLOR_W    = 8;
   localparam int PIXEL_W    = 3 * COLOR_W;
   localparam int PSUM_W     = COLOR_W + 1;      // sum of two components
   localparam int ENTRY_W    = 3 * PSUM_W;       // one line store entry
   localparam int SIZE_W     = 13;               // src_width / src_height registers
   localparam int FACTOR_W   = 4;
   localparam int ROW_W      = 12;               // row counter
   localparam int HEIGHT_W   = SIZE_W + 1;       // compare width on the row side
   localparam int HEIGHT_LIMIT = 4096;
   localparam int DEF_MAX_WIDTH = 4096;

   // register file
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;

   localparam logic [1:0] REG_SRC_WIDTH  = 2'd0;
   localparam logic [1:0] REG_SRC_HEIGHT = 2'd1;
   localparam logic [1:0] REG_FACTOR     = 2'd2;

   localparam logic [SIZE_W-1:0]   RST_SRC_WIDTH  = 13'd640;
   localparam logic [SIZE_W-1:0]   RST_SRC_HEIGHT = 13'd480;
   localparam logic [FACTOR_W-1:0] RST_FACTOR     = 4'd2;

   // position re-derivation after a register write
   typedef enum logic {
      DIV_IDLE,
      DIV_RUN
   } div_state_type;

   // one restoring division step: shift in one dividend bit, subtract the
   // divisor when it fits. Returns {quotient bit, new remainder}.
   function automatic logic [FACTOR_W:0] div_step(
      input logic [FACTOR_W-1:0] rem,
      input logic                bit_in,
      input logic [FACTOR_W-1:0] divisor
   );
      logic [FACTOR_W:0] t;
      logic [FACTOR_W:0] d;
      t = {rem, bit_in};
      d = {1'b0, divisor};
      if (t >= d) begin
         div_step = {1'b1, FACTOR_W'(t - d)};
      end else begin
         div_step = {1'b0, t[FACTOR_W-1:0]};
      end
   endfunction

endpackage

// File: hw/rtl/rbd_ram.sv
// rbd_ram: generic simple dual-port RAM, one write and one read port, registered read.
// No dependencies; used for the line store of rgb_box_downsampler_unit.
module rbd_ram #(
   parameter int WIDTH = 27,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: hw/rtl/rgb_box_downsampler_unit.sv
// rgb_box_downsampler_unit: top level of the RGB box downsampler (2x2 mean per block; factor 1 passes pixels through).
// Depends on rbd_pkg and rbd_ram (line store of per-column upper pair sums).
//
//   channel  | direction | handshake           | payload
//   ---------+-----------+---------------------+-------------------------------------
//   req      | in        | req_tvalid/tready   | tdata: red, green, blue; tuser: frame_start
//   rsp      | out       | rsp_tvalid/tready   | tdata: red, green, blue; tlast: frame_end
//   csr      | in        | psel/penable/pready | src_width @0, src_height @4, factor @8
//
// One input word per clock when the result side keeps up and no divider run or register
// write is under way. A result passes from stage 1 (the line store read) into the output
// register. The line store is read and written at most once per word.
// After any register write the column and row positions are re-split by the factor in a
// bit-serial divider; no input word is taken while it runs.
// Reset is synchronous; the line store is not cleared.
module rgb_box_downsampler_unit
   import rbd_pkg::*;
#(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   // input words
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [PIXEL_W-1:0]    req_tdata,   // [7:0] red_in, [15:8] green_in, [23:16] blue_in
   input  logic                  req_tuser,   // [0] frame_start
   // result words
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [PIXEL_W-1:0]    rsp_tdata,   // [7:0] red_out, [15:8] green_out, [23:16] blue_out
   output logic                  rsp_tlast,   // frame_end
   // configuration
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int CW    = $clog2(MAX_WIDTH);                      // column counter
   localparam int DEPTH = MAX_WIDTH / 2;
   localparam int AW    = $clog2(DEPTH);
   localparam int WW    = ((CW + 1 > SIZE_W) ? CW + 1 : SIZE_W) + 1; // width compares
   localparam int DW    = (CW > ROW_W) ? CW : ROW_W;              // divider length
   localparam int SCW   = $clog2(DW + 1);
   localparam logic [SCW-1:0] LAST_STEP = SCW'(DW - 1);
   localparam logic [WW-1:0]  W_MAX = WW'(MAX_WIDTH);
   localparam logic [WW-1:0]  W_MIN = WW'(2);
   localparam logic [HEIGHT_W-1:0] H_MAX = HEIGHT_W'(HEIGHT_LIMIT);
   localparam logic [HEIGHT_W-1:0] H_MIN = HEIGHT_W'(2);

   // ------------------------------------------------------------------
   // registers
   logic [SIZE_W-1:0]   src_width_ff,  src_width_in;
   logic [SIZE_W-1:0]   src_height_ff, src_height_in;
   logic [FACTOR_W-1:0] factor_ff,     factor_in;

   // position: col = bx + dx, bx = xx * f (same on the row side)
   logic [CW-1:0]       col_ff, col_in;
   logic [CW-1:0]       xx_ff,  xx_in;
   logic [CW-1:0]       bx_ff,  bx_in;
   logic [FACTOR_W-1:0] dx_ff,  dx_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [ROW_W-1:0]    yy_ff,  yy_in;
   logic [ROW_W-1:0]    by_ff,  by_in;
   logic [FACTOR_W-1:0] dy_ff,  dy_in;

   logic [PIXEL_W-1:0]  held_ff, held_in;

   // divider
   div_state_type       div_state_ff, div_state_in;
   logic [SCW-1:0]      step_ff, step_in;
   logic [DW-1:0]       dvc_ff, dvc_in;
   logic [DW-1:0]       dvr_ff, dvr_in;
   logic [FACTOR_W-1:0] remc_ff, remc_in;
   logic [FACTOR_W-1:0] remr_ff, remr_in;

   // stage 1 (line store read in flight) and output register
   logic                s1_valid_ff, s1_valid_in;
   logic                s1_pass_ff,  s1_pass_in;
   logic                s1_last_ff,  s1_last_in;
   logic [PSUM_W-1:0]   s1_r_ff, s1_r_in;
   logic [PSUM_W-1:0]   s1_g_ff, s1_g_in;
   logic [PSUM_W-1:0]   s1_b_ff, s1_b_in;
   logic                out_valid_ff, out_valid_in;
   logic                out_last_ff,  out_last_in;
   logic [PIXEL_W-1:0]  out_data_ff,  out_data_in;

   // ------------------------------------------------------------------
   // configuration port
   logic cfg_wr;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      src_width_in  = src_width_ff;
      src_height_in = src_height_ff;
      factor_in     = factor_ff;
      if (cfg_wr) begin
         case (csr_paddr[3:2])
            REG_SRC_WIDTH:  src_width_in  = csr_pwdata[SIZE_W-1:0];
            REG_SRC_HEIGHT: src_height_in = csr_pwdata[SIZE_W-1:0];
            REG_FACTOR:     factor_in     = csr_pwdata[FACTOR_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_SRC_WIDTH:  csr_prdata = CSR_DATA_W'(src_width_ff);
         REG_SRC_HEIGHT: csr_prdata = CSR_DATA_W'(src_height_ff);
         REG_FACTOR:     csr_prdata = CSR_DATA_W'(factor_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // effective sizes and factor
   logic [FACTOR_W-1:0] f_eff;
   logic [WW-1:0]       w_raw, w_eff;
   logic [HEIGHT_W-1:0] h_raw, h_eff;

   always_comb begin
      f_eff = (factor_ff == '0) ? FACTOR_W'(1) : factor_ff;
      w_raw = WW'(src_width_ff);
      if (w_raw < W_MIN)      w_eff = W_MIN;
      else if (w_raw > W_MAX) w_eff = W_MAX;
      else                    w_eff = w_raw;
      h_raw = HEIGHT_W'(src_height_ff);
      if (h_raw < H_MIN)      h_eff = H_MIN;
      else if (h_raw > H_MAX) h_eff = H_MAX;
      else                    h_eff = h_raw;
   end

   // ------------------------------------------------------------------
   // handshake
   logic out_free, s1_free, acc;
   assign out_free   = !out_valid_ff || rsp_tready;
   assign s1_free    = !s1_valid_ff || out_free;
   assign req_tready = (div_state_ff == DIV_IDLE) && !cfg_wr && s1_free;
   assign acc        = req_tvalid && req_tready;

   // ------------------------------------------------------------------
   // current position (frame_start restarts at the origin)
   logic [CW-1:0]       cur_col, cur_xx, cur_bx;
   logic [FACTOR_W-1:0] cur_dx, cur_dy;
   logic [ROW_W-1:0]    cur_row, cur_yy, cur_by;

   always_comb begin
      if (req_tuser) begin
         cur_col = '0; cur_xx = '0; cur_bx = '0; cur_dx = '0;
         cur_row = '0; cur_yy = '0; cur_by = '0; cur_dy = '0;
      end else begin
         cur_col = col_ff; cur_xx = xx_ff; cur_bx = bx_ff; cur_dx = dx_ff;
         cur_row = row_ff; cur_yy = yy_ff; cur_by = by_ff; cur_dy = dy_ff;
      end
   end

   // block decode
   logic [WW-1:0]       bx_end, bx_end2;
   logic [HEIGHT_W-1:0] by_end, by_end2;
   logic in_x, last_x, in_y, last_y;
   logic pass, in_blk, do_hold, do_write, do_read, pass_last;

   always_comb begin
      bx_end  = WW'(cur_bx) + WW'(f_eff);
      bx_end2 = bx_end + WW'(f_eff);
      by_end  = HEIGHT_W'(cur_by) + HEIGHT_W'(f_eff);
      by_end2 = by_end + HEIGHT_W'(f_eff);
      in_x    = bx_end <= w_eff;
      last_x  = bx_end2 > w_eff;
      in_y    = by_end <= h_eff;
      last_y  = by_end2 > h_eff;
      pass    = f_eff == FACTOR_W'(1);
      in_blk  = !pass && in_x && in_y && (cur_dx < FACTOR_W'(2)) && (cur_dy < FACTOR_W'(2));
      do_hold  = acc && in_blk && (cur_dx == '0);
      do_write = acc && in_blk && (cur_dx != '0) && (cur_dy == '0);
      do_read  = acc && in_blk && (cur_dx != '0) && (cur_dy != '0);
      pass_last = (WW'(cur_col) + WW'(1) == w_eff) &&
                  (HEIGHT_W'(cur_row) + HEIGHT_W'(1) == h_eff);
   end

   // ------------------------------------------------------------------
   // line store: written on the upper right corner, read on the lower right corner.
   // The read of an entry comes at least one row after its write, so no forwarding.
   logic [COLOR_W-1:0] pix_r, pix_g, pix_b, held_r, held_g, held_b;
   logic [PSUM_W-1:0]  pair_r, pair_g, pair_b;
   logic [ENTRY_W-1:0] ram_rdata;
   logic [AW-1:0]      ram_addr;

   assign pix_r  = req_tdata[COLOR_W-1:0];
   assign pix_g  = req_tdata[2*COLOR_W-1:COLOR_W];
   assign pix_b  = req_tdata[3*COLOR_W-1:2*COLOR_W];
   assign held_r = held_ff[COLOR_W-1:0];
   assign held_g = held_ff[2*COLOR_W-1:COLOR_W];
   assign held_b = held_ff[3*COLOR_W-1:2*COLOR_W];
   assign pair_r = PSUM_W'(held_r) + PSUM_W'(pix_r);
   assign pair_g = PSUM_W'(held_g) + PSUM_W'(pix_g);
   assign pair_b = PSUM_W'(held_b) + PSUM_W'(pix_b);
   assign ram_addr = cur_xx[AW-1:0];

   rbd_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_line_store (
      .clock (clock),
      .we    (do_write),
      .waddr (ram_addr),
      .wdata ({pair_b, pair_g, pair_r}),
      .re    (do_read),
      .raddr (ram_addr),
      .rdata (ram_rdata)
   );

   // ------------------------------------------------------------------
   // position advance and divider
   logic [CW:0]         col_p1;
   logic [ROW_W:0]      row_p1;
   logic [FACTOR_W:0]   dx_p1, dy_p1;
   logic [FACTOR_W:0]   stc, str;
   logic                div_last;

   always_comb begin
      col_p1 = {1'b0, cur_col} + (CW+1)'(1);
      row_p1 = {1'b0, cur_row} + (ROW_W+1)'(1);
      dx_p1  = {1'b0, cur_dx} + (FACTOR_W+1)'(1);
      dy_p1  = {1'b0, cur_dy} + (FACTOR_W+1)'(1);
      stc    = div_step(remc_ff, dvc_ff[DW-1], f_eff);
      str    = div_step(remr_ff, dvr_ff[DW-1], f_eff);
      div_last = step_ff == LAST_STEP;

      col_in = col_ff; xx_in = xx_ff; bx_in = bx_ff; dx_in = dx_ff;
      row_in = row_ff; yy_in = yy_ff; by_in = by_ff; dy_in = dy_ff;
      div_state_in = div_state_ff;
      step_in = step_ff;
      dvc_in  = dvc_ff;
      dvr_in  = dvr_ff;
      remc_in = remc_ff;
      remr_in = remr_ff;

      // one word accepted: step to the next pixel
      if (acc) begin
         if (WW'(col_p1) >= w_eff) begin
            col_in = '0; xx_in = '0; bx_in = '0; dx_in = '0;
            if (HEIGHT_W'(row_p1) >= h_eff) begin
               row_in = '0; yy_in = '0; by_in = '0; dy_in = '0;
            end else begin
               row_in = row_p1[ROW_W-1:0];
               if (dy_p1 == (FACTOR_W+1)'(f_eff)) begin
                  dy_in = '0;
                  yy_in = cur_yy + ROW_W'(1);
                  by_in = cur_by + ROW_W'(f_eff);
               end else begin
                  dy_in = dy_p1[FACTOR_W-1:0];
                  yy_in = cur_yy;
                  by_in = cur_by;
               end
            end
         end else begin
            col_in = col_p1[CW-1:0];
            row_in = cur_row; yy_in = cur_yy; by_in = cur_by; dy_in = cur_dy;
            if (dx_p1 == (FACTOR_W+1)'(f_eff)) begin
               dx_in = '0;
               xx_in = cur_xx + CW'(1);
               bx_in = cur_bx + CW'(f_eff);
            end else begin
               dx_in = dx_p1[FACTOR_W-1:0];
               xx_in = cur_xx;
               bx_in = cur_bx;
            end
         end
      end

      // divider: re-split column and row by the factor after a register write
      case (div_state_ff)
         DIV_IDLE: begin
         end
         DIV_RUN: begin
            dvc_in  = {dvc_ff[DW-2:0], stc[FACTOR_W]};
            dvr_in  = {dvr_ff[DW-2:0], str[FACTOR_W]};
            remc_in = stc[FACTOR_W-1:0];
            remr_in = str[FACTOR_W-1:0];
            step_in = step_ff + SCW'(1);
            if (div_last) begin
               div_state_in = DIV_IDLE;
               dx_in = stc[FACTOR_W-1:0];
               xx_in = dvc_in[CW-1:0];
               bx_in = col_ff - CW'(stc[FACTOR_W-1:0]);
               dy_in = str[FACTOR_W-1:0];
               yy_in = dvr_in[ROW_W-1:0];
               by_in = row_ff - ROW_W'(str[FACTOR_W-1:0]);
            end
         end
         default: div_state_in = DIV_IDLE;
      endcase

      if (cfg_wr) begin
         div_state_in = DIV_RUN;
         step_in = '0;
         dvc_in  = DW'(col_ff);
         dvr_in  = DW'(row_ff);
         remc_in = '0;
         remr_in = '0;
      end
   end

   // ------------------------------------------------------------------
   // held left pixel, stage 1 and output register
   logic [PSUM_W+1:0] tot_r, tot_g, tot_b;

   always_comb begin
      held_in = do_hold ? req_tdata : held_ff;

      s1_valid_in = (s1_valid_ff && !out_free) || (acc && (pass || do_read));
      s1_pass_in  = s1_pass_ff;
      s1_last_in  = s1_last_ff;
      s1_r_in = s1_r_ff;
      s1_g_in = s1_g_ff;
      s1_b_in = s1_b_ff;
      if (acc && pass) begin
         s1_pass_in = 1'b1;
         s1_last_in = pass_last;
         s1_r_in = PSUM_W'(pix_r);
         s1_g_in = PSUM_W'(pix_g);
         s1_b_in = PSUM_W'(pix_b);
      end else if (do_read) begin
         s1_pass_in = 1'b0;
         s1_last_in = last_x && last_y;
         s1_r_in = pair_r;
         s1_g_in = pair_g;
         s1_b_in = pair_b;
      end

      // lower pair plus stored upper pair, then divide by four
      tot_r = (PSUM_W+2)'(ram_rdata[PSUM_W-1:0]) + (PSUM_W+2)'(s1_r_ff);
      tot_g = (PSUM_W+2)'(ram_rdata[2*PSUM_W-1:PSUM_W]) + (PSUM_W+2)'(s1_g_ff);
      tot_b = (PSUM_W+2)'(ram_rdata[3*PSUM_W-1:2*PSUM_W]) + (PSUM_W+2)'(s1_b_ff);

      out_valid_in = (out_valid_ff && !rsp_tready) || (s1_valid_ff && out_free);
      out_last_in  = out_last_ff;
      out_data_in  = out_data_ff;
      if (s1_valid_ff && out_free) begin
         out_last_in = s1_last_ff;
         if (s1_pass_ff) begin
            out_data_in = {s1_b_ff[COLOR_W-1:0], s1_g_ff[COLOR_W-1:0], s1_r_ff[COLOR_W-1:0]};
         end else begin
            out_data_in = {tot_b[PSUM_W:2], tot_g[PSUM_W:2], tot_r[PSUM_W:2]};
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

   // ------------------------------------------------------------------
   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= RST_SRC_WIDTH;
         src_height_ff <= RST_SRC_HEIGHT;
         factor_ff     <= RST_FACTOR;
         col_ff <= '0; xx_ff <= '0; bx_ff <= '0; dx_ff <= '0;
         row_ff <= '0; yy_ff <= '0; by_ff <= '0; dy_ff <= '0;
         held_ff      <= '0;
         div_state_ff <= DIV_IDLE;
         step_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         src_width_ff  <= src_width_in;
         src_height_ff <= src_height_in;
         factor_ff     <= factor_in;
         col_ff <= col_in; xx_ff <= xx_in; bx_ff <= bx_in; dx_ff <= dx_in;
         row_ff <= row_in; yy_ff <= yy_in; by_ff <= by_in; dy_ff <= dy_in;
         held_ff      <= held_in;
         div_state_ff <= div_state_in;
         step_ff      <= step_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      dvc_ff      <= dvc_in;
      dvr_ff      <= dvr_in;
      remc_ff     <= remc_in;
      remr_ff     <= remr_in;
      s1_pass_ff  <= s1_pass_in;
      s1_last_ff  <= s1_last_in;
      s1_r_ff     <= s1_r_in;
      s1_g_ff     <= s1_g_in;
      s1_b_ff     <= s1_b_in;
      out_last_ff <= out_last_in;
      out_data_ff <= out_data_in;
   end

   // ------------------------------------------------------------------
`ifndef ASSERT_OFF
   a_ready_needs_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> div_state_ff == DIV_IDLE)
      else $error("input taken while position is being re-derived");

   a_col_split: assert property (@(posedge clock) disable iff (reset)
      div_state_ff == DIV_IDLE |-> (bx_ff + CW'(dx_ff)) == col_ff)
      else $error("column split out of step with column counter");

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      div_state_ff == DIV_IDLE |-> (dx_ff < f_eff) && (dy_ff < f_eff))
      else $error("block phase not below factor");

   a_read_fills_s1: assert property (@(posedge clock) disable iff (reset)
      do_read |=> s1_valid_ff && !s1_pass_ff)
      else $error("line store read without a stage 1 word");
`endif

endmodule
